/* design/sidt_pkg.sv */
// Shared sizes, codes and types for the string interning table.
// No dependencies; every other design file imports this package.
package sidt_pkg;

  localparam int MAX_ENTRIES      = 256;
  localparam int POOL_BYTES       = 65536;
  localparam int MAX_STRING_BYTES = 256;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int HASH_W  = 64;
  localparam int OFF_W   = 16;
  localparam int CODE_W  = 3;

  localparam int CNT_W   = $clog2(MAX_STRING_BYTES + 1);
  localparam int BUF_AW  = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;
  localparam int ENT_AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1);
  localparam int POOL_AW = $clog2(POOL_BYTES);
  localparam int FILL_W  = POOL_AW + 1;

  // Result codes
  localparam logic [CODE_W-1:0] OUT_FOUND      = 3'd0;
  localparam logic [CODE_W-1:0] OUT_RECORDED   = 3'd1;
  localparam logic [CODE_W-1:0] OUT_UNRECORDED = 3'd2;
  localparam logic [CODE_W-1:0] OUT_NULL       = 3'd3;
  localparam logic [CODE_W-1:0] OUT_FULL       = 3'd4;

  // One finished string handed from front to back
  typedef struct packed {
    logic              is_null;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

endpackage

/* design/sidt_front.sv */
// Front end: gathers string bytes into the incoming buffer and issues commands.
// Depends on sidt_pkg.
module sidt_front import sidt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] string_byte,
  input  logic [LEN_W-1:0]  string_length,
  input  logic [HASH_W-1:0] string_hash,
  input  logic              last_byte,
  input  logic              no_string,
  output logic              cmd_push,
  output cmd_t              cmd_data,
  input  logic              cmd_full,
  input  logic              release_buf,
  input  logic [BUF_AW-1:0] buf_raddr,
  output logic [BYTE_W-1:0] buf_rdata
);

  logic [BYTE_W-1:0] buf_mem [MAX_STRING_BYTES];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              busy;
  logic              accept;
  logic              room;
  logic [LEN_W-1:0]  len_sat;

  // Bytes are held off while the back end still reads the buffer
  assign full   = cmd_full || busy;
  assign accept = push && !full;
  assign room   = 32'(count) < MAX_STRING_BYTES;

  assign len_sat = (32'(string_length) > MAX_STRING_BYTES) ?
                   LEN_W'(MAX_STRING_BYTES) : string_length;

  always_comb begin
    count_next = count;
    if (room) begin
      count_next = count + CNT_W'(1);
    end
  end

  // A string ends on a null item, a zero length or the last byte
  always_comb begin
    cmd_push         = accept && (no_string || string_length == '0 || last_byte);
    cmd_data.is_null = no_string;
    cmd_data.hash    = string_hash;
    cmd_data.len     = len_sat;
    cmd_data.cnt     = (string_length == '0) ? '0 : count_next;
  end

  // Byte count and buffer lock
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (release_buf) begin
        busy <= 1'b0;
      end
      if (accept) begin
        if (cmd_push) begin
          count <= '0;
          busy  <= !no_string;
        end else begin
          count <= count_next;
        end
      end
    end
  end

  // Incoming buffer
  always_ff @(posedge clk) begin
    if (accept && !no_string && string_length != '0 && room) begin
      buf_mem[count[BUF_AW-1:0]] <= string_byte;
    end
    buf_rdata <= buf_mem[buf_raddr];
  end

endmodule

/* design/sidt_cmd_fifo.sv */
// Two-entry command queue between front and back.
// Depends on sidt_pkg.
module sidt_cmd_fifo import sidt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic valid
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] level;

  assign full  = level == 2'd2;
  assign valid = level != 2'd0;
  assign rdata = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      level <= level + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

/* design/sidt_back.sv */
// Back end: entry scan, pool compare, append, recording and result register.
// Depends on sidt_pkg; reads the front end's incoming buffer.
module sidt_back import sidt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd_data,
  output logic              cmd_pop,
  output logic              release_buf,
  output logic [BUF_AW-1:0] buf_raddr,
  input  logic [BYTE_W-1:0] buf_rdata,
  output logic              empty,
  input  logic              pop,
  output logic [OFF_W-1:0]  pool_offset,
  output logic [CODE_W-1:0] outcome
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN_RD = 4'd1;
  localparam logic [3:0] ST_SCAN_CK = 4'd2;
  localparam logic [3:0] ST_CMP_RD  = 4'd3;
  localparam logic [3:0] ST_CMP_CK  = 4'd4;
  localparam logic [3:0] ST_DECIDE  = 4'd5;
  localparam logic [3:0] ST_APP_RD  = 4'd6;
  localparam logic [3:0] ST_APP_WR  = 4'd7;
  localparam logic [3:0] ST_EMIT    = 4'd8;

  logic [HASH_W-1:0]  hash_mem [MAX_ENTRIES];
  logic [LEN_W-1:0]   len_mem  [MAX_ENTRIES];
  logic [POOL_AW-1:0] off_mem  [MAX_ENTRIES];
  logic [BYTE_W-1:0]  pool_mem [POOL_BYTES];

  logic [HASH_W-1:0]  t_hash;
  logic [LEN_W-1:0]   t_len;
  logic [POOL_AW-1:0] t_off;
  logic [BYTE_W-1:0]  pool_rdata;

  logic [3:0]         state;
  logic [HASH_W-1:0]  c_hash;
  logic [LEN_W-1:0]   c_len;
  logic [CNT_W-1:0]   c_cnt;
  logic [ENT_CW-1:0]  idx;
  logic [ENT_CW-1:0]  rec;
  logic [LEN_W-1:0]   k;
  logic [POOL_AW-1:0] e_off;
  logic [FILL_W-1:0]  fill;
  logic [POOL_AW-1:0] res_off;
  logic [CODE_W-1:0]  res_code;
  logic               out_valid;
  logic [OFF_W-1:0]   out_off;
  logic [CODE_W-1:0]  out_code;

  logic [FILL_W-1:0]  cmp_addr;
  logic [FILL_W+1:0]  need;
  logic [BYTE_W-1:0]  str_byte;
  logic               slot_free;
  logic [ENT_CW-1:0]  idx_inc;
  logic [31:0]        off_wide;

  assign cmp_addr  = FILL_W'(e_off) + FILL_W'(k);
  assign need      = (FILL_W+2)'(fill) + (FILL_W+2)'(c_len) + (FILL_W+2)'(1);
  assign str_byte  = (CNT_W'(k) < c_cnt) ? buf_rdata : '0;
  assign slot_free = !out_valid || pop;
  assign idx_inc   = idx + ENT_CW'(1);
  assign buf_raddr = k[BUF_AW-1:0];
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  // Entry tables: read at the scan index, written at the record count
  always_ff @(posedge clk) begin
    t_hash <= hash_mem[idx[ENT_AW-1:0]];
    t_len  <= len_mem[idx[ENT_AW-1:0]];
    t_off  <= off_mem[idx[ENT_AW-1:0]];
    if (state == ST_APP_WR && k == c_len && 32'(rec) < MAX_ENTRIES) begin
      hash_mem[rec[ENT_AW-1:0]] <= c_hash;
      len_mem[rec[ENT_AW-1:0]]  <= c_len;
      off_mem[rec[ENT_AW-1:0]]  <= fill[POOL_AW-1:0];
    end
  end

  // Byte pool
  always_ff @(posedge clk) begin
    pool_rdata <= pool_mem[cmp_addr[POOL_AW-1:0]];
    if (state == ST_APP_WR) begin
      pool_mem[POOL_AW'(fill + FILL_W'(k))] <= (k < c_len) ? str_byte : '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rec         <= '0;
      fill        <= '0;
      release_buf <= 1'b0;
    end else begin
      release_buf <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            c_hash <= cmd_data.hash;
            c_len  <= cmd_data.len;
            c_cnt  <= cmd_data.cnt;
            idx    <= '0;
            k      <= '0;
            if (cmd_data.is_null) begin
              res_off  <= '0;
              res_code <= OUT_NULL;
              state    <= ST_EMIT;
            end else if (rec == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CK;
        end
        ST_SCAN_CK: begin
          k <= '0;
          if (t_hash == c_hash && t_len == c_len) begin
            e_off <= t_off;
            if (c_len == '0) begin
              res_off     <= t_off;
              res_code    <= OUT_FOUND;
              release_buf <= 1'b1;
              state       <= ST_EMIT;
            end else begin
              state <= ST_CMP_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= (idx_inc == rec) ? ST_DECIDE : ST_SCAN_RD;
          end
        end
        ST_CMP_RD: begin
          state <= ST_CMP_CK;
        end
        ST_CMP_CK: begin
          if (32'(cmp_addr) >= POOL_BYTES || pool_rdata != str_byte) begin
            idx   <= idx_inc;
            k     <= '0;
            state <= (idx_inc == rec) ? ST_DECIDE : ST_SCAN_RD;
          end else if (k + LEN_W'(1) == c_len) begin
            res_off     <= e_off;
            res_code    <= OUT_FOUND;
            release_buf <= 1'b1;
            state       <= ST_EMIT;
          end else begin
            k     <= k + LEN_W'(1);
            state <= ST_CMP_RD;
          end
        end
        ST_DECIDE: begin
          k <= '0;
          if (32'(need) > POOL_BYTES) begin
            res_off     <= '0;
            res_code    <= OUT_FULL;
            release_buf <= 1'b1;
            state       <= ST_EMIT;
          end else begin
            state <= ST_APP_RD;
          end
        end
        ST_APP_RD: begin
          state <= ST_APP_WR;
        end
        ST_APP_WR: begin
          if (k == c_len) begin
            fill        <= FILL_W'(need);
            res_off     <= fill[POOL_AW-1:0];
            release_buf <= 1'b1;
            if (32'(rec) < MAX_ENTRIES) begin
              rec      <= rec + ENT_CW'(1);
              res_code <= OUT_RECORDED;
            end else begin
              res_code <= OUT_UNRECORDED;
            end
            state <= ST_EMIT;
          end else begin
            k     <= k + LEN_W'(1);
            state <= ST_APP_RD;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  assign off_wide = 32'(res_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_off  <= off_wide[OFF_W-1:0];
      out_code <= res_code;
    end
  end

  assign empty       = !out_valid;
  assign pool_offset = out_off;
  assign outcome     = out_code;

endmodule

/* design/string_intern_dedup_table.sv */
// Top level of the string interning table: front end, command queue, back end.
// Depends on sidt_pkg, sidt_front, sidt_cmd_fifo and sidt_back.
//
//   Channel   Handshake     Payload
//   input     push / full   string_byte, string_length, string_hash, last_byte, no_string
//   result    pop / empty   pool_offset, outcome
//
// Bytes are taken one per cycle while full is low; a finished string then locks
// the incoming buffer until the back end is done with it. The back end reads and
// checks each table entry scanned, reads and compares each pool byte, and writes
// length + 1 bytes when it appends; it takes no new command until it is idle.
// Reset (synchronous) clears counts and control only; no clearing pass.
// A waiting result stalls the back end only when a second result is ready.
module string_intern_dedup_table import sidt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] string_byte,
  input  logic [LEN_W-1:0]  string_length,
  input  logic [HASH_W-1:0] string_hash,
  input  logic              last_byte,
  input  logic              no_string,
  output logic              empty,
  input  logic              pop,
  output logic [OFF_W-1:0]  pool_offset,
  output logic [CODE_W-1:0] outcome
);

  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_valid;
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic              release_buf;
  logic [BUF_AW-1:0] buf_raddr;
  logic [BYTE_W-1:0] buf_rdata;

  sidt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .string_byte   (string_byte),
    .string_length (string_length),
    .string_hash   (string_hash),
    .last_byte     (last_byte),
    .no_string     (no_string),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .cmd_full      (cmd_full),
    .release_buf   (release_buf),
    .buf_raddr     (buf_raddr),
    .buf_rdata     (buf_rdata)
  );

  sidt_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_out),
    .valid (cmd_valid)
  );

  sidt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_data    (cmd_out),
    .cmd_pop     (cmd_pop),
    .release_buf (release_buf),
    .buf_raddr   (buf_raddr),
    .buf_rdata   (buf_rdata),
    .empty       (empty),
    .pop         (pop),
    .pool_offset (pool_offset),
    .outcome     (outcome)
  );

endmodule

/* test/string_intern_dedup_table_checker.sv */
// Checker for string_intern_dedup_table: watches both queue ports, predicts results.
// Depends on sidt_pkg for sizes and outcome codes.
`timescale 1ns / 1ps
module string_intern_dedup_table_checker import sidt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [BYTE_W-1:0] string_byte,
  input  logic [LEN_W-1:0]  string_length,
  input  logic [HASH_W-1:0] string_hash,
  input  logic              last_byte,
  input  logic              no_string,
  input  logic              empty,
  input  logic              pop,
  input  logic [OFF_W-1:0]  pool_offset,
  input  logic [CODE_W-1:0] outcome,
  output int                errors,
  output int                pending,
  output int                outcome_count [5]
);

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [CODE_W-1:0] code;
  } intern_result_t;

  // Mirror of the interning state
  logic [HASH_W-1:0] tbl_hash [MAX_ENTRIES];
  int                tbl_len  [MAX_ENTRIES];
  int                tbl_off  [MAX_ENTRIES];
  int                n_recorded;
  logic [7:0]        pool_mem [POOL_BYTES];
  int                pool_used;
  logic [7:0]        in_bytes [MAX_STRING_BYTES];
  int                in_count;

  intern_result_t    expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s at %0t: got %0d want %0d", what, $realtime, got, want);
    errors++;
  endtask

  function automatic logic [7:0] in_at(input int k);
    if (k < in_count && k < MAX_STRING_BYTES) return in_bytes[k];
    return 8'd0;
  endfunction

  function automatic bit pool_equal(input int off, input int len);
    for (int k = 0; k < len; k++) begin
      if (off + k >= POOL_BYTES) return 0;
      if (pool_mem[off + k] != in_at(k)) return 0;
    end
    return 1;
  endfunction

  function automatic void expect_result(input int off, input logic [CODE_W-1:0] code);
    intern_result_t r;
    r.off  = off[OFF_W-1:0];
    r.code = code;
    expected_results.push_back(r);
    in_count = 0;
  endfunction

  // Fold one accepted item into the mirror; queue a result at a string end
  function automatic void intern_item(input logic [7:0] b, input int len,
                                      input logic [HASH_W-1:0] h, input bit last,
                                      input bit none);
    int l;
    int off;
    if (none) begin
      expect_result(0, OUT_NULL);
      return;
    end
    if (len == 0) begin
      in_count = 0;
    end else begin
      if (in_count < MAX_STRING_BYTES) begin
        in_bytes[in_count] = b;
        in_count++;
      end
      if (!last) return;
    end
    l = (len > MAX_STRING_BYTES) ? MAX_STRING_BYTES : len;
    for (int i = 0; i < n_recorded; i++) begin
      if (tbl_hash[i] == h && tbl_len[i] == l && pool_equal(tbl_off[i], l)) begin
        expect_result(tbl_off[i], OUT_FOUND);
        return;
      end
    end
    if (POOL_BYTES - pool_used < l + 1) begin
      expect_result(0, OUT_FULL);
      return;
    end
    off = pool_used;
    for (int k = 0; k < l; k++) pool_mem[off + k] = in_at(k);
    pool_mem[off + l] = 8'd0;
    pool_used = off + l + 1;
    if (n_recorded < MAX_ENTRIES) begin
      tbl_hash[n_recorded] = h;
      tbl_len[n_recorded]  = l;
      tbl_off[n_recorded]  = off;
      n_recorded++;
      expect_result(off, OUT_RECORDED);
    end else begin
      expect_result(off, OUT_UNRECORDED);
    end
  endfunction

  initial begin
    errors = 0;
    n_recorded = 0;
    pool_used = 0;
    in_count = 0;
    for (int i = 0; i < 5; i++) outcome_count[i] = 0;
  end

  // Input side: predict on every accepted item
  always @(posedge clk) begin
    if (!rst && push && !full)
      intern_item(string_byte, int'(string_length), string_hash, last_byte, no_string);
  end

  // Result side: compare against the oldest prediction
  always @(posedge clk) begin
    intern_result_t want;
    if (!rst && pop && !empty) begin
      if (outcome < 5) outcome_count[outcome]++;
      if (expected_results.size() == 0) begin
        report("unexpected result, outcome", int'(outcome), -1);
      end else begin
        want = expected_results.pop_front();
        if (outcome != want.code) report("outcome", int'(outcome), int'(want.code));
        if (pool_offset != want.off) report("pool_offset", int'(pool_offset), int'(want.off));
      end
    end
  end

endmodule

/* test/string_intern_dedup_table_tb.sv */
// Testbench top for string_intern_dedup_table: clock, reset, stimulus and verdict.
// Depends on sidt_pkg, the design, and string_intern_dedup_table_checker.
`timescale 1ns / 1ps
module string_intern_dedup_table_tb import sidt_pkg::*;;

  localparam int STALL_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  logic              clk = 0;
  logic              rst = 1;
  logic              push = 0;
  logic              full;
  logic [BYTE_W-1:0] string_byte = '0;
  logic [LEN_W-1:0]  string_length = '0;
  logic [HASH_W-1:0] string_hash = '0;
  logic              last_byte = 0;
  logic              no_string = 0;
  logic              empty;
  logic              pop = 0;
  logic [OFF_W-1:0]  pool_offset;
  logic [CODE_W-1:0] outcome;

  int errors;
  int pending;
  int outcome_count [5];
  bit quiet = 0;
  bit hold_req = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  // Strings sent so far, kept flat so they can be resent as duplicates
  logic [7:0]        sent_bytes [$];
  int                sent_start [$];
  int                sent_len [$];
  logic [HASH_W-1:0] sent_hash [$];
  logic [7:0]        str_buf [MAX_STRING_BYTES];

  always #5 clk = ~clk;

  string_intern_dedup_table i_dut (.*);

  string_intern_dedup_table_checker i_checker (.*);

  // Watchdog: cycles with no traffic on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result drain with random stalls and one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        pop <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pop <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        pop <= 1;
      end else begin
        pop <= 1;
      end
    end
  end

  // Offer one item and wait until it is taken
  task automatic send_item(input logic [7:0] b, input int len, input logic [HASH_W-1:0] h,
                           input bit last, input bit none);
    push          <= 1;
    string_byte   <= b;
    string_length <= len[LEN_W-1:0];
    string_hash   <= h;
    last_byte     <= last;
    no_string     <= none;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Well-formed string from str_buf; remembered for later duplicates
  task automatic send_string(input logic [HASH_W-1:0] h, input int n);
    sent_start.push_back(sent_bytes.size());
    sent_len.push_back(n);
    sent_hash.push_back(h);
    for (int k = 0; k < n; k++) sent_bytes.push_back(str_buf[k]);
    if (n == 0) begin
      send_item(8'($urandom_range(0, 255)), 0, h, 1'($urandom_range(0, 1)), 0);
    end else begin
      for (int k = 0; k < n; k++) send_item(str_buf[k], n, h, k == n - 1, 0);
    end
  endtask

  task automatic resend(input int idx);
    int n;
    n = sent_len[idx];
    for (int k = 0; k < n; k++) str_buf[k] = sent_bytes[sent_start[idx] + k];
    send_string(sent_hash[idx], n);
  endtask

  function automatic logic [HASH_W-1:0] pick_hash();
    if ($urandom_range(0, 2) == 0) return HASH_W'($urandom_range(0, 7));
    return {$urandom, $urandom};
  endfunction

  // Short random string: mostly fresh, often a repeat, sometimes malformed
  task automatic random_string();
    int n;
    int sel;
    logic [HASH_W-1:0] h;
    sel = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
    h = pick_hash();
    for (int k = 0; k < n; k++) str_buf[k] = 8'($urandom_range(0, 255));
    if (sel < 35 && sent_len.size() > 0) begin
      resend($urandom_range(0, sent_len.size() - 1));
    end else if (sel < 40) begin
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 511), pick_hash(), 0, 1);
    end else if (sel < 45 && n > 1) begin
      // cut short by a null or an empty string
      send_item(str_buf[0], n, h, 0, 0);
      send_item(8'($urandom_range(0, 255)), 0, h, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else if (sel < 50 && n > 1) begin
      // fewer bytes than the length says
      for (int k = 0; k < n - 1; k++) send_item(str_buf[k], n + 2, h, k == n - 2, 0);
    end else if (sel < 55 && n > 0) begin
      // extra bytes past the length
      for (int k = 0; k < n + 2; k++) begin
        send_item(8'($urandom_range(0, 255)), n, h, k == n + 1, 0);
      end
    end else begin
      send_string(h, n);
    end
  endtask

  initial begin
    logic [HASH_W-1:0] h;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: null, empty, insert, find, hash collision, aborted strings
    send_item(8'hFF, 9'h1FF, '1, 1, 1);
    send_item(8'h00, 0, '0, 0, 0);
    str_buf[0] = 8'h61; str_buf[1] = 8'hFF;
    send_string(64'h1, 2);
    resend(sent_len.size() - 1);
    str_buf[0] = 8'h00; str_buf[1] = 8'h62;
    send_string(64'h1, 2);
    send_item(8'h11, 3, 64'h2, 0, 0);
    send_item(8'h22, 3, 64'h2, 1, 1);
    send_item(8'h33, 3, 64'h3, 0, 0);
    send_item(8'h44, 0, 64'h3, 1, 0);
    send_item(8'h55, 5, 64'h4, 0, 0);
    send_item(8'h66, 5, 64'h4, 1, 0);
    send_item(8'h77, 1, 64'h5, 0, 0);
    send_item(8'h88, 1, 64'h5, 0, 0);
    send_item(8'h99, 1, 64'h5, 1, 0);
    // over-long length saturates; stored twice the same way gives a find
    send_item(8'hFF, 300, '1, 1, 0);
    send_item(8'hFF, 300, '1, 1, 0);
    send_item(8'h00, 256, 64'h8000_0000_0000_0000, 1, 0);
    send_item(8'h00, 256, 64'h8000_0000_0000_0000, 1, 0);

    // Random short strings; enough of them to run past the entry table
    for (int s = 0; items_sent < 1300; s++) begin
      if (s == 150) hold_req = 1;
      if (s == 300) begin
        // sender pauses until every result has come back
        push <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_string();
    end

    // Large strings until the pool runs out
    for (int s = 0; s < 262; s++) begin
      h = {$urandom, $urandom};
      send_item(8'($urandom_range(0, 255)), $urandom_range(256, 511), h, 1, 0);
    end

    // Last stretch with no stalls on either side
    quiet = 1;
    while (items_sent < 1700) random_string();

    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    $display("sent %0d items; results found %0d, recorded %0d, unrecorded %0d,",
             items_sent, outcome_count[0], outcome_count[1], outcome_count[2]);
    $display("null %0d, pool full %0d", outcome_count[3], outcome_count[4]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
